/* hdl/ncm_pkg.sv */
// ----------------------------------------------------------------------------
// ncm_pkg
// Shared types and codes for the nearest color match block: the request and
// result payloads and the request type codes.
// ----------------------------------------------------------------------------
package ncm_pkg;

  localparam int CHAN_W       = 10;
  localparam int ENTRY_IDX_W  = 4;
  localparam int MATCH_IDX_W  = 4;
  localparam int MATCH_DIST_W = 11;
  localparam int COUNT_W      = 5;

  localparam logic REQ_WRITE    = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  typedef struct packed {
    logic                   req_type;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [CHAN_W-1:0]      red_value;
    logic [CHAN_W-1:0]      green_value;
    logic [CHAN_W-1:0]      blue_value;
  } in_item_t;

  typedef struct packed {
    logic [MATCH_IDX_W-1:0]  match_index;
    logic [MATCH_DIST_W-1:0] match_distance;
    logic                    match_found;
  } out_item_t;

endpackage

/* hdl/ncm_table.sv */
// ----------------------------------------------------------------------------
// ncm_table
// Reference signature store: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module ncm_table #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 30,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/ncm_dist.sv */
// ----------------------------------------------------------------------------
// ncm_dist
// Weighted distance unit: squares the channel differences, forms
// 5dr^2 + 5dg^2 + 4db^2 and finds the largest k with 5k^2 not above it, one
// bit of k per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module ncm_dist #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [3*SAMPLE_BITS-1:0] sample,
  input  logic [3*SAMPLE_BITS-1:0] ref_entry,
  output logic                     done,
  output logic [SAMPLE_BITS:0]     distance
);

  localparam int SW   = SAMPLE_BITS;
  localparam int QW   = 2 * SW;
  localparam int SUMW = 2 * SW + 5;
  localparam int KW   = SW + 1;
  localparam int JW   = $clog2(SW + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SUM  = 2'd1;
  localparam logic [1:0] PH_ROOT = 2'd2;

  logic [1:0]      phase_r;
  logic            done_r;
  logic [QW-1:0]   sq_red_r, sq_green_r, sq_blue_r;
  logic [SUMW-1:0] sum_r;
  logic [SUMW-1:0] acc_r;
  logic [KW-1:0]   root_r;
  logic [JW-1:0]   bit_r;

  logic [SW-1:0]   diff_red, diff_green, diff_blue;
  logic [SW-1:0]   s_red, s_green, s_blue, e_red, e_green, e_blue;
  logic [SUMW-1:0] root_x10, cand;

  assign s_red   = sample[3*SW-1:2*SW];
  assign s_green = sample[2*SW-1:SW];
  assign s_blue  = sample[SW-1:0];
  assign e_red   = ref_entry[3*SW-1:2*SW];
  assign e_green = ref_entry[2*SW-1:SW];
  assign e_blue  = ref_entry[SW-1:0];

  assign diff_red   = (s_red   >= e_red)   ? s_red   - e_red   : e_red   - s_red;
  assign diff_green = (s_green >= e_green) ? s_green - e_green : e_green - s_green;
  assign diff_blue  = (s_blue  >= e_blue)  ? s_blue  - e_blue  : e_blue  - s_blue;

  // Trial value 5(k + 2^j)^2 = 5k^2 + 10k*2^j + 5*4^j, where k holds only bits above j.
  assign root_x10 = (SUMW'(root_r) << 3) + (SUMW'(root_r) << 1);
  assign cand     = acc_r + (root_x10 << bit_r) + (SUMW'(5) << {bit_r, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (phase_r)
        PH_IDLE: begin
          if (start) begin
            phase_r <= PH_SUM;
          end
        end
        PH_SUM: begin
          phase_r <= PH_ROOT;
        end
        PH_ROOT: begin
          if (bit_r == '0) begin
            done_r  <= 1'b1;
            phase_r <= PH_IDLE;
          end
        end
        default: begin
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == PH_IDLE && start) begin
      sq_red_r   <= QW'(diff_red * diff_red);
      sq_green_r <= QW'(diff_green * diff_green);
      sq_blue_r  <= QW'(diff_blue * diff_blue);
    end
    if (phase_r == PH_SUM) begin
      sum_r  <= (SUMW'(sq_red_r) << 2) + SUMW'(sq_red_r)
              + (SUMW'(sq_green_r) << 2) + SUMW'(sq_green_r)
              + (SUMW'(sq_blue_r) << 2);
      acc_r  <= '0;
      root_r <= '0;
      bit_r  <= JW'(SW);
    end
    if (phase_r == PH_ROOT) begin
      if (cand <= sum_r) begin
        acc_r  <= cand;
        root_r <= root_r | (KW'(1) << bit_r);
      end
      if (bit_r != '0) begin
        bit_r <= bit_r - JW'(1);
      end
    end
  end

  assign done     = done_r;
  assign distance = root_r;

endmodule

/* hdl/nearest_color_match.sv */
// ----------------------------------------------------------------------------
// nearest_color_match
// Nearest reference color classifier with a weighted Euclidean distance.
// ----------------------------------------------------------------------------
// A write request (req_type 0) stores one RGB reference in the table at the
// edge it is accepted and gives no result. A classify request compares its
// signature with entries 0 to entry_count-1 (capped at MAX_ENTRIES) and gives
// one result, on out_data for exactly one cycle with out_valid high; it
// cannot be held off. When no entries are in use, the result comes in the
// cycle after the classify is accepted, with match_found low. Each entry
// costs a table read, a squaring step, a summing step and the iterative root,
// one bit per cycle, and busy stays high until the strobe. A write is done in
// its accept cycle. Read only entries that were written. The user must write
// entry_count through the cfg port only while the block is idle; the block
// itself does not enforce this.
module nearest_color_match
  import ncm_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_item_t           in_data,
  output logic               out_valid,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  localparam int SW  = SAMPLE_BITS;
  localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int IW  = (AW > ENTRY_IDX_W) ? AW : ENTRY_IDX_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_LOAD  = 2'd2;
  localparam logic [1:0] ST_CALC  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [COUNT_W-1:0] entry_count_r;
  logic [CW-1:0]      scan_r, scan_nxt;
  logic [CW-1:0]      limit_r, limit;
  logic [3*SW-1:0]    sample_r;
  logic [AW-1:0]      best_idx_r;
  logic [SW:0]        best_dist_r;
  logic               found_r;
  logic               out_valid_r;

  logic               accept;
  logic               wr_en;
  logic [IW-1:0]      wr_idx;
  logic [3*SW-1:0]    in_sample;
  logic               rd_en;
  logic [3*SW-1:0]    rd_data;
  logic               dist_start;
  logic               dist_done;
  logic [SW:0]        distance;
  logic               last_entry;

  assign accept    = start && !busy;
  assign in_sample = {SW'(in_data.red_value), SW'(in_data.green_value),
                      SW'(in_data.blue_value)};
  assign wr_idx    = IW'(in_data.entry_index);
  assign wr_en     = accept && in_data.req_type == REQ_WRITE
                     && int'(in_data.entry_index) < MAX_ENTRIES;

  assign limit = (int'(entry_count_r) > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
                                                      : CW'(entry_count_r);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count_r <= cfg_data;
    end
  end

  // Reads and writes never overlap: writes are taken only while idle, and a
  // classify reads the table only while busy is high.
  ncm_table #(
    .DEPTH  (MAX_ENTRIES),
    .WIDTH  (3 * SW),
    .ADDR_W (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (in_sample),
    .rd_en   (rd_en),
    .rd_addr (scan_r[AW-1:0]),
    .rd_data (rd_data)
  );

  ncm_dist #(
    .SAMPLE_BITS (SW)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (dist_start),
    .sample    (sample_r),
    .ref_entry (rd_data),
    .done      (dist_done),
    .distance  (distance)
  );

  assign rd_en      = state_r == ST_FETCH;
  assign dist_start = state_r == ST_LOAD;
  assign last_entry = scan_r + CW'(1) == limit_r;

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_data.req_type == REQ_CLASSIFY && limit != '0) begin
          state_nxt = ST_FETCH;
          scan_nxt  = '0;
        end
      end
      ST_FETCH: state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_CALC;
      ST_CALC: begin
        if (dist_done) begin
          if (last_entry) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_FETCH;
            scan_nxt  = scan_r + CW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && in_data.req_type == REQ_CLASSIFY && limit == '0)
                     || (state_r == ST_CALC && dist_done && last_entry);
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    if (accept && in_data.req_type == REQ_CLASSIFY) begin
      sample_r    <= in_sample;
      limit_r     <= limit;
      best_idx_r  <= '0;
      best_dist_r <= '0;
      found_r     <= 1'b0;
    end else if (state_r == ST_CALC && dist_done) begin
      // Strictly smaller only, so a tie keeps the lower index.
      if (!found_r || distance < best_dist_r) begin
        best_idx_r  <= scan_r[AW-1:0];
        best_dist_r <= distance;
      end
      found_r <= 1'b1;
    end
  end

  assign busy                    = state_r != ST_IDLE;
  assign out_valid               = out_valid_r;
  assign out_data.match_index    = MATCH_IDX_W'(best_idx_r);
  assign out_data.match_distance = MATCH_DIST_W'(best_dist_r);
  assign out_data.match_found    = found_r;

  // A result is shown only once the scan has finished.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result strobe while a scan is still running");

  // The distance unit reports only for a scan in progress.
  assert property (@(posedge clk) disable iff (!rst_n) dist_done |-> state_r == ST_CALC)
    else $error("distance unit finished outside a scan");

  // An empty comparison leaves index and distance at zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.match_found |->
      out_data.match_index == '0 && out_data.match_distance == '0)
    else $error("no-match result carries a nonzero index or distance");

  // A scan never goes beyond the entries in use.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FETCH |-> scan_r < limit_r)
    else $error("table read beyond the entries in use");

endmodule
